@@ rtl/gtm_pkg.sv @@
package gtm_pkg;

  localparam int MAX_POPULATION_DEF = 512;

  localparam int COST_W  = 32;
  localparam int GEN_W   = 20;
  localparam int IDX_W   = 9;
  localparam int STAGE_W = 2;
  localparam int CFG_W   = 33;
  localparam int CFG_IDX_W = 3;

  localparam int POP_W   = 10;
  localparam int SLIM_W  = 11;
  localparam int MSTAG_W = 17;
  localparam int TGT_W   = 33;
  localparam int MGEN_W  = 21;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // x / 10 == (x * 0xCCCCD) >> 23 for every 20-bit x
  localparam logic [GEN_W-1:0] DIV10_MUL = 20'hCCCCD;
  localparam int DIV10_SHIFT = 23;

  localparam logic [POP_W-1:0]   POP_SIZE_RST   = 10'd300;
  localparam logic [SLIM_W-1:0]  STAG_LIMIT_RST = 11'd50;

  localparam logic [STAGE_W-1:0] STAGE_ONE = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_TWO = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POP_SIZE        = 3'd0,
    REG_STAG_LIMIT      = 3'd1,
    REG_MAX_STAGNATION  = 3'd2,
    REG_TARGET_COST     = 3'd3,
    REG_MAX_GENERATIONS = 3'd4
  } gtm_reg_idx_t;

  typedef struct packed {
    logic [COST_W-1:0] best;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  gen;
    logic              all_eq;
  } gtm_entry_t;

  typedef struct packed {
    logic [SLIM_W-1:0]         stag_limit;
    logic signed [MSTAG_W-1:0] max_stagnation;
    logic signed [TGT_W-1:0]   target_cost;
    logic signed [MGEN_W-1:0]  max_generations;
  } gtm_limits_t;

endpackage

@@ rtl/ga_generation_termination_monitor_unit.sv @@
// Generation termination monitor.
// Input channel: one tour cost per population member (in_cost), with the
// generation number (in_generation) sampled on the member that completes the
// generation. An item is taken when in_valid is high and in_stall is low.
// Output channel: one result per completed generation (terminate, stage,
// best index, best cost), taken when out_valid is high and out_stall is low.
// Config: cfg_we writes cfg_data to register cfg_index (0 pop_size,
// 1 stag_limit, 2 max_stagnation, 3 target_cost, 4 max_generations).
// Throughput: one cost item per cycle while in_stall is low. A completed
// generation goes through a record stage and a 4-entry queue to the
// decision stage, which retires one generation per cycle while the output
// register is free. After the generation's last item is taken, its result
// passes the record register and the queue to the output register (out_valid).
// When out_stall holds, finished generations collect in the queue; in_stall
// rises once three of them wait. Reset restores the config registers to defaults
// and clears all accumulators and counters; no clearing pass is needed.
module ga_generation_termination_monitor_unit #(
  parameter int MAX_POPULATION = gtm_pkg::MAX_POPULATION_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gtm_pkg::COST_W-1:0]      in_cost,
  input  logic [gtm_pkg::GEN_W-1:0]       in_generation,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_terminate,
  output logic [gtm_pkg::STAGE_W-1:0]     out_stage,
  output logic [gtm_pkg::IDX_W-1:0]       out_best_index,
  output logic [gtm_pkg::COST_W-1:0]      out_best_cost,
  input  logic                            cfg_we,
  input  logic [gtm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gtm_pkg::CFG_W-1:0]       cfg_data
);
  import gtm_pkg::*;

  logic [POP_W-1:0] pop_size_r;
  gtm_limits_t      limits_r;

  logic             push;
  gtm_entry_t       push_entry;
  logic             pop;
  logic             head_valid;
  gtm_entry_t       head_entry;
  logic             almost_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_size_r               <= POP_SIZE_RST;
      limits_r.stag_limit      <= STAG_LIMIT_RST;
      limits_r.max_stagnation  <= '1;
      limits_r.target_cost     <= '1;
      limits_r.max_generations <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POP_SIZE:        pop_size_r               <= cfg_data[POP_W-1:0];
        REG_STAG_LIMIT:      limits_r.stag_limit      <= cfg_data[SLIM_W-1:0];
        REG_MAX_STAGNATION:  limits_r.max_stagnation  <= cfg_data[MSTAG_W-1:0];
        REG_TARGET_COST:     limits_r.target_cost     <= cfg_data[TGT_W-1:0];
        REG_MAX_GENERATIONS: limits_r.max_generations <= cfg_data[MGEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = almost_full;

  gtm_front #(
    .MAX_POPULATION(MAX_POPULATION)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cost       (in_cost),
    .in_generation (in_generation),
    .pop_size      (pop_size_r),
    .push          (push),
    .push_entry    (push_entry)
  );

  gtm_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_entry  (push_entry),
    .pop         (pop),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .almost_full (almost_full)
  );

  gtm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (pop),
    .limits         (limits_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_terminate  (out_terminate),
    .out_stage      (out_stage),
    .out_best_index (out_best_index),
    .out_best_cost  (out_best_cost)
  );

endmodule

@@ rtl/gtm_front.sv @@
module gtm_front #(
  parameter int MAX_POPULATION = gtm_pkg::MAX_POPULATION_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [gtm_pkg::COST_W-1:0]  in_cost,
  input  logic [gtm_pkg::GEN_W-1:0]   in_generation,
  input  logic [gtm_pkg::POP_W-1:0]   pop_size,
  output logic                        push,
  output gtm_pkg::gtm_entry_t         push_entry
);
  import gtm_pkg::*;

  localparam int CNT_W = $clog2(MAX_POPULATION + 1);
  localparam int SUM_W = COST_W + CNT_W;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [COST_W-1:0] min_r, min_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;

  logic              rec_valid_r, rec_valid_nxt;
  logic [COST_W-1:0] rec_best_r;
  logic [CNT_W-1:0]  rec_idx_r;
  logic [CNT_W-1:0]  rec_cnt_r;
  logic [SUM_W-1:0]  rec_sum_r;
  logic [GEN_W-1:0]  rec_gen_r;

  logic [CNT_W-1:0]  pop_eff;
  logic              accept;
  logic              take;
  logic [COST_W-1:0] upd_min;
  logic [CNT_W-1:0]  upd_idx;
  logic [SUM_W-1:0]  upd_sum;
  logic [CNT_W-1:0]  upd_cnt;
  logic              gen_end;
  logic [SUM_W-1:0]  eq_prod;

  always_comb begin
    if (pop_size == '0) begin
      pop_eff = CNT_W'(1);
    end else if (32'(pop_size) > 32'(MAX_POPULATION)) begin
      pop_eff = CNT_W'(MAX_POPULATION);
    end else begin
      pop_eff = CNT_W'(pop_size);
    end
  end

  assign accept  = in_valid && !in_stall;
  assign take    = (cnt_r == '0) || (in_cost < min_r);
  assign upd_min = take ? in_cost : min_r;
  assign upd_idx = take ? cnt_r : idx_r;
  assign upd_sum = sum_r + SUM_W'(in_cost);
  assign upd_cnt = cnt_r + CNT_W'(1);
  assign gen_end = upd_cnt >= pop_eff;

  always_comb begin
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    idx_nxt       = idx_r;
    rec_valid_nxt = 1'b0;
    if (accept) begin
      if (gen_end) begin
        cnt_nxt       = '0;
        sum_nxt       = '0;
        min_nxt       = '0;
        idx_nxt       = '0;
        rec_valid_nxt = 1'b1;
      end else begin
        cnt_nxt = upd_cnt;
        sum_nxt = upd_sum;
        min_nxt = upd_min;
        idx_nxt = upd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_r       <= '0;
      min_r       <= '0;
      idx_r       <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      idx_r       <= idx_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && gen_end) begin
      rec_best_r <= upd_min;
      rec_idx_r  <= upd_idx;
      rec_cnt_r  <= upd_cnt;
      rec_sum_r  <= upd_sum;
      rec_gen_r  <= in_generation;
    end
  end

  // all costs equal when sum <= count * min
  assign eq_prod = SUM_W'(rec_cnt_r) * SUM_W'(rec_best_r);

  assign push              = rec_valid_r;
  assign push_entry.best   = rec_best_r;
  assign push_entry.idx    = IDX_W'(rec_idx_r);
  assign push_entry.gen    = rec_gen_r;
  assign push_entry.all_eq = rec_sum_r <= eq_prod;

endmodule

@@ rtl/gtm_queue.sv @@
module gtm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gtm_pkg::gtm_entry_t  push_entry,
  input  logic                 pop,
  output logic                 head_valid,
  output gtm_pkg::gtm_entry_t  head_entry,
  output logic                 almost_full
);
  import gtm_pkg::*;

  gtm_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_pop;

  assign head_valid  = cnt_r != '0;
  assign head_entry  = mem_r[rd_ptr_r];
  assign almost_full = cnt_r >= Q_CNT_W'(Q_DEPTH - 1);
  assign do_pop      = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/gtm_back.sv @@
module gtm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  gtm_pkg::gtm_entry_t            head_entry,
  output logic                           pop,
  input  gtm_pkg::gtm_limits_t           limits,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_terminate,
  output logic [gtm_pkg::STAGE_W-1:0]    out_stage,
  output logic [gtm_pkg::IDX_W-1:0]      out_best_index,
  output logic [gtm_pkg::COST_W-1:0]     out_best_cost
);
  import gtm_pkg::*;

  localparam int PROD_W = 2 * GEN_W;
  localparam logic [GEN_W-1:0] CNT_MAX = '1;

  logic [COST_W-1:0]  prev_best_r, prev_best_nxt;
  logic [GEN_W-1:0]   stall_r, stall_nxt;
  logic [GEN_W-1:0]   dyn_r, dyn_nxt;
  logic [STAGE_W-1:0] stage_r, stage_nxt;
  logic [GEN_W-1:0]   s2gen_r, s2gen_nxt;
  logic [GEN_W-1:0]   gstag_r, gstag_nxt;
  logic [COST_W-1:0]  gbest_r, gbest_nxt;
  logic               ov_r, ov_nxt;
  logic               term_r, term_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [COST_W-1:0]  best_r;

  logic [GEN_W-1:0]   stall_upd;
  logic [GEN_W-1:0]   span;
  logic [PROD_W-1:0]  div_prod;
  logic [GEN_W-1:0]   span_div10;
  logic               hit_stag;
  logic               hit_target;
  logic               hit_gen;

  assign pop = head_valid && (!ov_r || !out_stall);

  assign stall_upd = (head_entry.best < prev_best_r) ? '0 :
                     (stall_r == CNT_MAX) ? CNT_MAX : stall_r + GEN_W'(1);

  always_comb begin
    if (head_entry.best < gbest_r) begin
      gstag_nxt = '0;
      gbest_nxt = head_entry.best;
    end else begin
      gstag_nxt = (gstag_r == CNT_MAX) ? CNT_MAX : gstag_r + GEN_W'(1);
      gbest_nxt = gbest_r;
    end
  end

  assign span       = (stage_r == STAGE_ONE) ? head_entry.gen : head_entry.gen - s2gen_r;
  assign div_prod   = PROD_W'(span) * PROD_W'(DIV10_MUL);
  assign span_div10 = GEN_W'(div_prod >> DIV10_SHIFT);

  assign hit_stag = (limits.max_stagnation != '1) &&
                    ($signed({1'b0, gstag_nxt}) >=
                     $signed({{(GEN_W + 1 - MSTAG_W){limits.max_stagnation[MSTAG_W-1]}},
                              limits.max_stagnation}));
  assign hit_target = (limits.target_cost != '1) &&
                      ($signed({2'b00, head_entry.best}) <=
                       $signed({limits.target_cost[TGT_W-1], limits.target_cost}));
  assign hit_gen = (limits.max_generations != '1) &&
                   ($signed({1'b0, head_entry.gen}) >= limits.max_generations);

  always_comb begin
    prev_best_nxt = prev_best_r;
    stall_nxt     = stall_r;
    dyn_nxt       = dyn_r;
    stage_nxt     = stage_r;
    s2gen_nxt     = s2gen_r;
    term_nxt      = term_r;
    ov_nxt        = ov_r && out_stall;
    if (pop) begin
      ov_nxt        = 1'b1;
      prev_best_nxt = head_entry.best;
      stall_nxt     = stall_upd;
      term_nxt      = 1'b0;
      if (hit_stag || hit_target || hit_gen || head_entry.all_eq) begin
        term_nxt = 1'b1;
      end else if (stall_upd == GEN_W'(limits.stag_limit) && dyn_r == '0) begin
        dyn_nxt = span_div10;
      end else if (dyn_r != '0 && dyn_r <= stall_upd) begin
        if (stage_r == STAGE_ONE) begin
          stall_nxt = '0;
          dyn_nxt   = '0;
          s2gen_nxt = head_entry.gen;
          stage_nxt = STAGE_TWO;
        end else begin
          term_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_best_r <= '1;
      stall_r     <= '0;
      dyn_r       <= '0;
      stage_r     <= STAGE_ONE;
      s2gen_r     <= '0;
      gstag_r     <= '0;
      gbest_r     <= '1;
      ov_r        <= 1'b0;
      term_r      <= 1'b0;
    end else begin
      prev_best_r <= prev_best_nxt;
      stall_r     <= stall_nxt;
      dyn_r       <= dyn_nxt;
      stage_r     <= stage_nxt;
      s2gen_r     <= s2gen_nxt;
      if (pop) begin
        gstag_r <= gstag_nxt;
        gbest_r <= gbest_nxt;
      end
      ov_r        <= ov_nxt;
      term_r      <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx_r  <= head_entry.idx;
      best_r <= head_entry.best;
    end
  end

  assign out_valid      = ov_r;
  assign out_terminate  = term_r;
  assign out_stage      = stage_r;
  assign out_best_index = idx_r;
  assign out_best_cost  = best_r;

endmodule

@@ tb/sv/tb_ga_generation_termination_monitor_unit.sv @@
`timescale 1ns / 100ps

module tb_ga_generation_termination_monitor_unit;
  import gtm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_W-1:0] LIMIT_OFF = '1;

  typedef struct {
    logic [COST_W-1:0] cost;
    logic [GEN_W-1:0]  gen;
  } tour_t;

  typedef struct {
    logic               stop;
    logic [STAGE_W-1:0] stage;
    logic [IDX_W-1:0]   at;
    logic [COST_W-1:0]  best;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COST_W-1:0]    in_cost = '0;
  logic [GEN_W-1:0]     in_generation = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_terminate;
  logic [STAGE_W-1:0]   out_stage;
  logic [IDX_W-1:0]     out_best_index;
  logic [COST_W-1:0]    out_best_cost;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  ga_generation_termination_monitor_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cost        (in_cost),
    .in_generation  (in_generation),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_terminate  (out_terminate),
    .out_stage      (out_stage),
    .out_best_index (out_best_index),
    .out_best_cost  (out_best_cost),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // shadow of the register file
  logic [POP_W-1:0]          set_pop = POP_SIZE_RST;
  logic [SLIM_W-1:0]         set_stag_limit = STAG_LIMIT_RST;
  logic signed [MSTAG_W-1:0] set_max_stag = '1;
  logic signed [TGT_W-1:0]   set_target = '1;
  logic signed [MGEN_W-1:0]  set_max_gen = '1;

  // predicted block state
  int unsigned        members = 0;
  logic [63:0]        run_sum = '0;
  logic [COST_W-1:0]  run_min = '0;
  logic [IDX_W-1:0]   run_min_at = '0;
  logic [COST_W-1:0]  prev_best = '1;
  logic [GEN_W-1:0]   stall_cnt = '0;
  logic [GEN_W-1:0]   dyn_limit = '0;
  logic [STAGE_W-1:0] stage_now = STAGE_ONE;
  logic [GEN_W-1:0]   stage2_gen = '0;
  logic [GEN_W-1:0]   glob_stag = '0;
  logic [COST_W-1:0]  glob_best = '1;

  tour_t    tours_waiting[$];
  verdict_t verdicts[$];
  tour_t    nxt;

  int tx_idle = 0;
  int rx_idle = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int hold_left = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int mismatches = 0;
  int cycles = 0;

  logic [COST_W-1:0] level;
  logic [GEN_W-1:0]  gen_no;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_pop();
    if (set_pop == '0) return 1;
    if (32'(set_pop) > MAX_POPULATION_DEF) return MAX_POPULATION_DEF;
    return 32'(set_pop);
  endfunction

  function automatic logic [GEN_W-1:0] bump(logic [GEN_W-1:0] x);
    return (&x) ? x : x + GEN_W'(1);
  endfunction

  function automatic int next_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one cost item in; a verdict comes out when the generation is complete
  function automatic void absorb_cost(logic [COST_W-1:0] c, logic [GEN_W-1:0] g);
    logic [COST_W-1:0] best;
    logic [GEN_W-1:0]  span;
    logic              stop;
    verdict_t          v;
    if (members == 0 || c < run_min) begin
      run_min = c;
      run_min_at = members[IDX_W-1:0];
    end
    run_sum += 64'(c);
    members++;
    if (members < eff_pop()) return;

    best = run_min;
    stall_cnt = (best < prev_best) ? '0 : bump(stall_cnt);
    prev_best = best;
    if (best < glob_best) begin
      glob_stag = '0;
      glob_best = best;
    end else begin
      glob_stag = bump(glob_stag);
    end

    stop = 1'b0;
    if (!(&set_max_stag) && $signed({1'b0, glob_stag}) >= 21'(set_max_stag)) begin
      stop = 1'b1;
    end else if (!(&set_target) && $signed({1'b0, best}) <= set_target) begin
      stop = 1'b1;
    end else if (!(&set_max_gen) && $signed({1'b0, g}) >= set_max_gen) begin
      stop = 1'b1;
    end else if (run_sum <= 64'(members) * 64'(best)) begin
      stop = 1'b1;
    end else begin
      span = (stage_now == STAGE_ONE) ? g : g - stage2_gen;
      if (stall_cnt == GEN_W'(set_stag_limit) && dyn_limit == '0) begin
        dyn_limit = span / GEN_W'(10);
      end else if (dyn_limit != '0 && dyn_limit <= stall_cnt) begin
        if (stage_now == STAGE_ONE) begin
          stall_cnt = '0;
          dyn_limit = '0;
          stage2_gen = g;
          stage_now = STAGE_TWO;
        end else begin
          stop = 1'b1;
        end
      end
    end

    v.stop = stop;
    v.stage = stage_now;
    v.at = run_min_at;
    v.best = best;
    verdicts.push_back(v);
    members = 0;
    run_sum = '0;
    run_min = '0;
    run_min_at = '0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_cost(in_cost, in_generation);
      if (!in_valid || !in_stall) begin
        if (tx_idle > 0) begin
          tx_idle <= tx_idle - 1;
          in_valid <= 1'b0;
        end else if (tours_waiting.size() != 0) begin
          nxt = tours_waiting.pop_front();
          in_valid <= 1'b1;
          in_cost <= nxt.cost;
          in_generation <= nxt.gen;
          tx_idle <= next_gap(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_verdict();
    verdict_t want;
    if (verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: stop %0b stage %0d idx %0d best %h",
                 out_terminate, out_stage, out_best_index, out_best_cost);
    end else begin
      want = verdicts.pop_front();
      if (out_terminate !== want.stop || out_stage !== want.stage ||
          out_best_index !== want.at || out_best_cost !== want.best) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0b/%0d/%0d/%h, got %0b/%0d/%0d/%h",
                   want.stop, want.stage, want.at, want.best,
                   out_terminate, out_stage, out_best_index, out_best_cost);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_verdict();
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (rx_idle > 0) begin
        out_stall <= 1'b1;
        rx_idle <= rx_idle - 1;
      end else begin
        out_stall <= 1'b0;
        rx_idle <= next_gap(rx_calm);
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_given != hold_asked) begin
      hold_left <= HOLD_CYCLES;
      hold_given <= hold_given + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(gtm_reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_POP_SIZE:        set_pop = val[POP_W-1:0];
      REG_STAG_LIMIT:      set_stag_limit = val[SLIM_W-1:0];
      REG_MAX_STAGNATION:  set_max_stag = val[MSTAG_W-1:0];
      REG_TARGET_COST:     set_target = val[TGT_W-1:0];
      REG_MAX_GENERATIONS: set_max_gen = val[MGEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic offer(logic [COST_W-1:0] c, logic [GEN_W-1:0] g);
    tour_t t;
    t.cost = c;
    t.gen = g;
    tours_waiting.push_back(t);
  endtask

  // one well-formed generation around the current cost level
  task automatic offer_generation(logic [GEN_W-1:0] g, bit improve, bit flat);
    int unsigned n;
    int unsigned lead;
    logic [COST_W-1:0] c;
    n = eff_pop();
    if (improve && level > 1000) level -= $urandom_range(1, 500);
    lead = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      c = ($urandom_range(0, 3) == 0) ? level : level + $urandom_range(1, 300);
      if (k == lead || flat) c = level;
      offer(c, g);
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (tours_waiting.size() != 0 || in_valid || verdicts.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned r;
    logic [CFG_W-1:0] val;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_POP_SIZE, 33'd1);
    write_reg(REG_STAG_LIMIT, 33'd1);
    write_reg(REG_MAX_STAGNATION, LIMIT_OFF);
    write_reg(REG_TARGET_COST, LIMIT_OFF);
    write_reg(REG_MAX_GENERATIONS, LIMIT_OFF);
    @(negedge clk);
    offer(32'd0, 20'd0);
    offer('1, '1);
    offer(32'd5, 20'd3);
    drain();

    // zero population acts as one
    write_reg(REG_POP_SIZE, 33'd0);
    @(negedge clk);
    offer(32'd7, 20'd1);
    offer(32'd7, 20'd2);
    drain();

    // first index wins on ties
    write_reg(REG_POP_SIZE, 33'd3);
    @(negedge clk);
    offer(32'd7, 20'd5);
    offer(32'd3, 20'd5);
    offer(32'd3, 20'd5);
    offer('1, 20'd6);
    offer(32'd0, 20'd6);
    offer(32'd0, 20'd6);
    drain();

    write_reg(REG_TARGET_COST, 33'd10);
    @(negedge clk);
    offer(32'd9, 20'd7);
    offer(32'd20, 20'd7);
    offer(32'd30, 20'd7);
    drain();
    write_reg(REG_TARGET_COST, 33'h1_FFFF_FFFB);
    @(negedge clk);
    offer(32'd1, 20'd8);
    offer(32'd2, 20'd8);
    offer(32'd3, 20'd8);
    drain();
    write_reg(REG_TARGET_COST, LIMIT_OFF);

    write_reg(REG_MAX_GENERATIONS, 33'd100);
    @(negedge clk);
    offer(32'd4, 20'd99);
    offer(32'd8, 20'd99);
    offer(32'd9, 20'd99);
    offer(32'd4, 20'd100);
    offer(32'd5, 20'd100);
    offer(32'd6, 20'd100);
    drain();
    write_reg(REG_MAX_GENERATIONS, 33'h0_001F_FFFD);
    @(negedge clk);
    offer(32'd50, 20'd101);
    offer(32'd60, 20'd101);
    offer(32'd70, 20'd101);
    drain();
    write_reg(REG_MAX_GENERATIONS, LIMIT_OFF);

    write_reg(REG_MAX_STAGNATION, 33'd1);
    @(negedge clk);
    offer(32'd10, 20'd102);
    offer(32'd11, 20'd102);
    offer(32'd12, 20'd102);
    offer(32'd10, 20'd103);
    offer(32'd20, 20'd103);
    offer(32'd30, 20'd103);
    drain();
    write_reg(REG_MAX_STAGNATION, 33'h0_0001_FFFE);
    @(negedge clk);
    offer(32'd2, 20'd104);
    offer(32'd1, 20'd104);
    offer(32'd9, 20'd104);
    drain();
    write_reg(REG_MAX_STAGNATION, LIMIT_OFF);

    // population lowered while a generation is partly in
    write_reg(REG_POP_SIZE, 33'd4);
    @(negedge clk);
    offer(32'd100, 20'd105);
    offer(32'd200, 20'd105);
    drain();
    write_reg(REG_POP_SIZE, 33'd2);
    @(negedge clk);
    offer(32'd300, 20'd105);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      @(negedge clk);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      level = $urandom_range(32'h0010_0000, 32'h7FFF_0000);
      gen_no = ($urandom_range(0, 3) == 0) ? GEN_W'($urandom_range(0, 20'hFFFFF)) :
                                             GEN_W'($urandom_range(0, 40));

      r = $urandom_range(0, 9);
      case (r)
        0: val = 33'd0;
        1: val = 33'd1;
        2: val = CFG_W'($urandom_range(7, 40));
        default: val = CFG_W'($urandom_range(2, 6));
      endcase
      if (ph == 2 || ph == 5) val = 33'd2;
      write_reg(REG_POP_SIZE, val);

      r = $urandom_range(0, 9);
      case (r)
        0: val = 33'd1500;
        1: val = 33'd2047;
        2: val = CFG_W'($urandom_range(1, 2047));
        default: val = CFG_W'($urandom_range(1, 4));
      endcase
      write_reg(REG_STAG_LIMIT, val);

      r = $urandom_range(0, 9);
      case (r)
        0: val = CFG_W'($urandom_range(2, 30));
        1: val = 33'h0_0000_FFFF;
        2: val = 33'h0_0001_0000;
        default: val = LIMIT_OFF;
      endcase
      write_reg(REG_MAX_STAGNATION, val);

      r = $urandom_range(0, 9);
      case (r)
        0: val = CFG_W'(level - $urandom_range(0, 3000));
        1: val = 33'h0_FFFF_FFFF;
        2: val = 33'h1_0000_0000;
        default: val = LIMIT_OFF;
      endcase
      write_reg(REG_TARGET_COST, val);

      r = $urandom_range(0, 9);
      case (r)
        0, 1: val = CFG_W'(21'(gen_no + $urandom_range(5, 40)));
        2: val = 33'h0_000F_FFFF;
        3: val = 33'h0_0010_0000;
        default: val = LIMIT_OFF;
      endcase
      write_reg(REG_MAX_GENERATIONS, val);

      @(negedge clk);
      if (ph == 2 || ph == 5) hold_asked++;
      sent = 0;
      while (sent < 24) begin
        r = $urandom_range(0, 19);
        if (r < 15) begin
          offer_generation(gen_no, $urandom_range(0, 5) == 0, $urandom_range(0, 19) == 0);
          gen_no++;
          sent += eff_pop();
        end else if (r < 18) begin
          offer($urandom, GEN_W'($urandom_range(0, 20'hFFFFF)));
          sent++;
        end else if (r == 18) begin
          gen_no = gen_no - GEN_W'($urandom_range(1, 40));
        end else begin
          gen_no = GEN_W'($urandom_range(0, 20'hFFFFF));
        end
      end
      drain();
    end

    // population above the maximum acts as the maximum
    write_reg(REG_POP_SIZE, 33'd1023);
    write_reg(REG_STAG_LIMIT, 33'd2047);
    @(negedge clk);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    offer_generation(gen_no, 1'b1, 1'b0);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
